// File: hw/rtl/dotq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the deadline ordered timer queue.
// No dependencies; imported by the top level, the port checks and the testbench.
package dotq_pkg;

  // Fixed field widths of the input and result words
  localparam int CMD_W     = 2;
  localparam int SLOT_IN_W = 4;
  localparam int STATUS_W  = 2;

  // Defaults for the top-level parameters
  localparam int DEF_SLOTS     = 16;
  localparam int DEF_TIME_BITS = 32;

  // Command codes of the input word
  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_START    = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_t;

  // Status codes of the result word
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_DUE    = 2'd1,
    ST_NOT_QUEUED = 2'd2
  } status_t;

endpackage

// File: hw/rtl/deadline_ordered_timer_queue.sv
`timescale 1ns / 1ps
// Top level of the deadline ordered timer queue: sequencer, slot tables, queue.
// Depends on dotq_pkg, dotq_ram and dotq_alu.
//
//  Channel | Direction | Handshake           | Word fields
//  in_     | input     | in_valid / in_stall | command, slot, interval, periodic, delay, now
//  out_    | output    | out_valid/out_stall | fired, fired_slot, status
//
// One word is processed at a time; in_stall is high from acceptance until the result is
// loaded into the output register. Register, delete of an unqueued slot, out-of-range
// slots and a tick that fires nothing do not walk the queue; removal and sorted insertion
// walk it entry by entry, both limited by the single read port of the queue order RAM.
// Reset is synchronous; the queue is empty afterward and no clearing pass is needed. A
// stalled result holds the output register; a new word may be accepted while it waits.
module deadline_ordered_timer_queue #(
  parameter int SLOTS     = dotq_pkg::DEF_SLOTS,
  parameter int TIME_BITS = dotq_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dotq_pkg::CMD_W-1:0]    in_command,
  input  logic [dotq_pkg::SLOT_IN_W-1:0] in_slot,
  input  logic [TIME_BITS-1:0]          in_interval,
  input  logic                          in_periodic,
  input  logic [TIME_BITS-1:0]          in_delay,
  input  logic [TIME_BITS-1:0]          in_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_fired,
  output logic [dotq_pkg::SLOT_IN_W-1:0] out_fired_slot,
  output logic [dotq_pkg::STATUS_W-1:0] out_status
);

  import dotq_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DISP    = 16'h0002,
    S_H_RD    = 16'h0004,
    S_H_DL    = 16'h0008,
    S_H_CMP   = 16'h0010,
    S_RM_RD   = 16'h0020,
    S_RM_CHK  = 16'h0040,
    S_ST_ADD1 = 16'h0080,
    S_ST_ADD2 = 16'h0100,
    S_PR_RD   = 16'h0200,
    S_PR_ADD  = 16'h0400,
    S_INS_BEG = 16'h0800,
    S_INS_ORD = 16'h1000,
    S_INS_DL  = 16'h2000,
    S_INS_CMP = 16'h4000,
    S_OUT     = 16'h8000
  } state_t;

  // Sequencer and work registers
  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic                 slot_ok_r, slot_ok_nxt;
  logic [SLOT_W-1:0]    wslot_r, wslot_nxt;
  logic [TIME_BITS-1:0] ivl_r, ivl_nxt;
  logic                 per_in_r, per_in_nxt;
  logic [TIME_BITS-1:0] dly_r, dly_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 flag_r, flag_nxt;
  logic [SLOT_W-1:0]    carry_r, carry_nxt;
  logic [SLOT_W-1:0]    cur_r, cur_nxt;
  logic                 res_fired_r, res_fired_nxt;
  status_t              res_status_r, res_status_nxt;

  // Per-slot flags
  logic [SLOTS-1:0]     queued_r, queued_nxt;
  logic [SLOTS-1:0]     per_r, per_nxt;
  logic [SLOTS-1:0]     ivl_vld_r, ivl_vld_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fired_r, out_fired_nxt;
  logic [SLOT_IN_W-1:0] out_slot_r, out_slot_nxt;
  status_t              out_status_r, out_status_nxt;

  // RAM ports
  logic                 ord_we;
  logic [SLOT_W-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                 dl_we;
  logic [TIME_BITS-1:0] dl_rdata;
  logic                 ivl_we;
  logic [TIME_BITS-1:0] ivl_rdata, ivl_val;

  // Shared unit
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_borrow;

  logic in_acc, out_free;

  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign ivl_val  = ivl_vld_r[wslot_r] ? ivl_rdata : '0;

  // Queue order: slot indices sorted by deadline
  dotq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS), .AW(SLOT_W)) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Deadline table, read at the slot just fetched from the queue
  dotq_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS), .AW(SLOT_W)) u_deadline (
    .clk   (clk),
    .we    (dl_we),
    .waddr (wslot_r),
    .wdata (alu_sum),
    .raddr (ord_rdata),
    .rdata (dl_rdata)
  );

  // Interval table, always read at the working slot
  dotq_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS), .AW(SLOT_W)) u_interval (
    .clk   (clk),
    .we    (ivl_we),
    .waddr (wslot_r),
    .wdata (ivl_r),
    .raddr (wslot_r),
    .rdata (ivl_rdata)
  );

  dotq_alu #(.W(TIME_BITS)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  // Select operands for the shared unit
  always_comb begin
    alu_a   = dl_r;
    alu_b   = dl_rdata;
    alu_sub = 1'b1;
    unique case (state_r)
      S_ST_ADD1: begin
        alu_a   = now_r;
        alu_b   = dly_r;
        alu_sub = 1'b0;
      end
      S_ST_ADD2: begin
        alu_a   = dl_r;
        alu_b   = ivl_val;
        alu_sub = 1'b0;
      end
      S_PR_ADD: begin
        alu_a   = now_r;
        alu_b   = ivl_val;
        alu_sub = 1'b0;
      end
      S_H_CMP: begin
        alu_a   = now_r;
        alu_b   = dl_rdata;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = dl_r;
        alu_b   = dl_rdata;
        alu_sub = 1'b1;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    slot_ok_nxt    = slot_ok_r;
    wslot_nxt      = wslot_r;
    ivl_nxt        = ivl_r;
    per_in_nxt     = per_in_r;
    dly_nxt        = dly_r;
    now_nxt        = now_r;
    dl_nxt         = dl_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    flag_nxt       = flag_r;
    carry_nxt      = carry_r;
    cur_nxt        = cur_r;
    res_fired_nxt  = res_fired_r;
    res_status_nxt = res_status_r;
    queued_nxt     = queued_r;
    per_nxt        = per_r;
    ivl_vld_nxt    = ivl_vld_r;
    out_valid_nxt  = out_valid_r;
    out_fired_nxt  = out_fired_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    ord_we         = 1'b0;
    ord_waddr      = idx_r[SLOT_W-1:0];
    ord_wdata      = carry_r;
    ord_raddr      = idx_r[SLOT_W-1:0];
    dl_we          = 1'b0;
    ivl_we         = 1'b0;

    // Drop the result word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Capture the input word
        if (in_acc) begin
          cmd_nxt     = cmd_t'(in_command);
          slot_ok_nxt = (32'(in_slot) < 32'(SLOTS));
          wslot_nxt   = SLOT_W'(in_slot);
          ivl_nxt     = in_interval;
          per_in_nxt  = in_periodic;
          dly_nxt     = in_delay;
          now_nxt     = in_now;
          state_nxt   = S_DISP;
        end
      end

      S_DISP: begin
        res_fired_nxt  = 1'b0;
        res_status_nxt = ST_DONE;
        idx_nxt        = '0;
        flag_nxt       = 1'b0;
        if (cmd_r == CMD_TICK) begin
          if (cnt_r == '0) begin
            res_status_nxt = ST_NOT_DUE;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_H_RD;
          end
        end else if (!slot_ok_r) begin
          res_status_nxt = ST_NOT_QUEUED;
          state_nxt      = S_OUT;
        end else begin
          unique case (cmd_r)
            CMD_REGISTER: begin
              ivl_we               = 1'b1;
              ivl_vld_nxt[wslot_r] = 1'b1;
              per_nxt[wslot_r]     = per_in_r;
              state_nxt            = S_OUT;
            end
            CMD_START: begin
              state_nxt = queued_r[wslot_r] ? S_RM_RD : S_ST_ADD1;
            end
            default: begin
              if (queued_r[wslot_r]) begin
                state_nxt = S_RM_RD;
              end else begin
                res_status_nxt = ST_NOT_QUEUED;
                state_nxt      = S_OUT;
              end
            end
          endcase
        end
      end

      // Fetch the head slot and its deadline
      S_H_RD: begin
        ord_raddr = '0;
        state_nxt = S_H_DL;
      end

      S_H_DL: begin
        wslot_nxt = ord_rdata;
        state_nxt = S_H_CMP;
      end

      S_H_CMP: begin
        if (alu_borrow) begin
          res_status_nxt = ST_NOT_DUE;
          state_nxt      = S_OUT;
        end else begin
          res_fired_nxt = 1'b1;
          idx_nxt       = '0;
          flag_nxt      = 1'b0;
          state_nxt     = S_RM_RD;
        end
      end

      // Remove: walk the queue, shift entries after the match down by one
      S_RM_RD: begin
        state_nxt = S_RM_CHK;
      end

      S_RM_CHK: begin
        if (flag_r) begin
          ord_we    = 1'b1;
          ord_waddr = SLOT_W'(idx_r - 1'b1);
          ord_wdata = ord_rdata;
        end
        if (ord_rdata == wslot_r) begin
          flag_nxt = 1'b1;
        end
        if (CNT_W'(idx_r + 1'b1) == cnt_r) begin
          cnt_nxt             = CNT_W'(cnt_r - 1'b1);
          queued_nxt[wslot_r] = 1'b0;
          if (cmd_r == CMD_START) begin
            state_nxt = S_ST_ADD1;
          end else if (cmd_r == CMD_TICK && per_r[wslot_r]) begin
            state_nxt = S_PR_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          state_nxt = S_RM_RD;
        end
      end

      // Start deadline: now + delay, then + interval
      S_ST_ADD1: begin
        dl_nxt    = alu_sum;
        state_nxt = S_ST_ADD2;
      end

      S_ST_ADD2: begin
        dl_nxt    = alu_sum;
        dl_we     = 1'b1;
        state_nxt = S_INS_BEG;
      end

      // Periodic rearm: now + interval
      S_PR_RD: begin
        state_nxt = S_PR_ADD;
      end

      S_PR_ADD: begin
        dl_nxt    = alu_sum;
        dl_we     = 1'b1;
        state_nxt = S_INS_BEG;
      end

      S_INS_BEG: begin
        idx_nxt  = '0;
        flag_nxt = 1'b0;
        if (cnt_r == FULL_CNT) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_INS_ORD;
        end
      end

      // Insert: walk the queue, place the slot before the first later deadline
      S_INS_ORD: begin
        if (idx_r == cnt_r) begin
          ord_we              = 1'b1;
          ord_waddr           = idx_r[SLOT_W-1:0];
          ord_wdata           = flag_r ? carry_r : wslot_r;
          cnt_nxt             = CNT_W'(cnt_r + 1'b1);
          queued_nxt[wslot_r] = 1'b1;
          state_nxt           = S_OUT;
        end else begin
          state_nxt = S_INS_DL;
        end
      end

      S_INS_DL: begin
        cur_nxt = ord_rdata;
        if (flag_r) begin
          // Already placed: ripple the carried entry up one
          ord_we    = 1'b1;
          ord_wdata = carry_r;
          carry_nxt = ord_rdata;
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          state_nxt = S_INS_ORD;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (alu_borrow) begin
          ord_we    = 1'b1;
          ord_wdata = wslot_r;
          carry_nxt = cur_r;
          flag_nxt  = 1'b1;
        end
        idx_nxt   = CNT_W'(idx_r + 1'b1);
        state_nxt = S_INS_ORD;
      end

      // Load the result word when the output register is free
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = res_fired_r;
          out_slot_nxt   = res_fired_r ? SLOT_IN_W'(wslot_r) : '0;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      queued_r    <= '0;
      per_r       <= '0;
      ivl_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      queued_r    <= queued_nxt;
      per_r       <= per_nxt;
      ivl_vld_r   <= ivl_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_ok_r    <= slot_ok_nxt;
    wslot_r      <= wslot_nxt;
    ivl_r        <= ivl_nxt;
    per_in_r     <= per_in_nxt;
    dly_r        <= dly_nxt;
    now_r        <= now_nxt;
    dl_r         <= dl_nxt;
    idx_r        <= idx_nxt;
    flag_r       <= flag_nxt;
    carry_r      <= carry_nxt;
    cur_r        <= cur_nxt;
    res_fired_r  <= res_fired_nxt;
    res_status_r <= res_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_slot_r;
  assign out_status     = out_status_r;

endmodule

// File: hw/rtl/dotq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dotq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/dotq_alu.sv
`timescale 1ns / 1ps
// Shared adder/subtractor used for deadline sums and unsigned compares.
// No dependencies.
module dotq_alu #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         borrow
);

  logic [W:0] ext;

  // Add, or subtract via inverted operand and carry in
  assign ext    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
  assign sum    = ext[W-1:0];
  // Borrow out means a < b unsigned
  assign borrow = sub & ~ext[W];

endmodule

// File: hw/rtl/dotq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the deadline ordered timer queue, bound to the top level.
// Depends on dotq_pkg.
module dotq_port_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_fired,
  input logic [dotq_pkg::SLOT_IN_W-1:0] out_fired_slot,
  input logic [dotq_pkg::STATUS_W-1:0]  out_status
);

  import dotq_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fired) &&
      $stable(out_fired_slot) && $stable(out_status))
    else $error("result word changed while stalled");

  // One word in flight: stall right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // A fired slot always reports done
  a_fired_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_status == ST_DONE)
    else $error("fired word with non-done status");

  // No fired slot index without a fire
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_slot == '0)
    else $error("slot index reported without fire");

  // Status code stays in its defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_DONE || out_status == ST_NOT_DUE ||
      out_status == ST_NOT_QUEUED)
    else $error("undefined status code");

endmodule

bind deadline_ordered_timer_queue dotq_port_props u_dotq_port_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_fired      (out_fired),
  .out_fired_slot (out_fired_slot),
  .out_status     (out_status)
);

// File: dv/dotq_checker.sv
`timescale 1ns / 1ps
// Checker for the deadline ordered timer queue: watches the input and result channels,
// keeps its own copy of the slot tables and the deadline-sorted queue, and compares words.
// Depends on dotq_pkg.
module dotq_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [dotq_pkg::CMD_W-1:0]          in_command,
  input  logic [dotq_pkg::SLOT_IN_W-1:0]      in_slot,
  input  logic [dotq_pkg::DEF_TIME_BITS-1:0]  in_interval,
  input  logic                                in_periodic,
  input  logic [dotq_pkg::DEF_TIME_BITS-1:0]  in_delay,
  input  logic [dotq_pkg::DEF_TIME_BITS-1:0]  in_now,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_fired,
  input  logic [dotq_pkg::SLOT_IN_W-1:0]      out_fired_slot,
  input  logic [dotq_pkg::STATUS_W-1:0]       out_status,
  output int                                  fail_count,
  output int                                  outstanding
);

  import dotq_pkg::*;

  localparam int NSLOT = DEF_SLOTS;
  localparam int TW    = DEF_TIME_BITS;

  typedef logic [SLOT_IN_W-1:0] slot_idx_t;
  typedef logic [TW-1:0]        ticks_t;

  typedef struct packed {
    logic      fired;
    slot_idx_t fired_slot;
    status_t   status;
  } timer_answer_t;

  // Slot tables and the deadline-sorted list of queued slots
  ticks_t        period_tab [NSLOT];
  ticks_t        deadline_tab [NSLOT];
  logic          rearm_tab [NSLOT];
  logic          armed_tab [NSLOT];
  slot_idx_t     due_order [$];
  timer_answer_t timer_answers [$];

  // Take a slot out of the sorted list and mark it idle
  function automatic void unlink_slot(input slot_idx_t s);
    for (int i = 0; i < due_order.size(); i++) begin
      if (due_order[i] == s) begin
        due_order.delete(i);
        break;
      end
    end
    armed_tab[s] = 1'b0;
  endfunction

  // Insert after every entry with an equal or earlier deadline
  function automatic void link_slot(input slot_idx_t s);
    int pos;
    if (due_order.size() >= NSLOT) return;
    pos = due_order.size();
    for (int i = 0; i < due_order.size(); i++) begin
      if (deadline_tab[s] < deadline_tab[due_order[i]]) begin
        pos = i;
        break;
      end
    end
    due_order.insert(pos, s);
    armed_tab[s] = 1'b1;
  endfunction

  // Apply one command word to the tables and return the answer it yields
  function automatic timer_answer_t apply_timer_cmd(input cmd_t cmd, input slot_idx_t s,
                                                    input ticks_t ivl, input logic per,
                                                    input ticks_t dly, input ticks_t now);
    timer_answer_t a;
    slot_idx_t     h;
    a = '0;
    a.status = ST_DONE;
    if (cmd == CMD_TICK) begin
      if (due_order.size() == 0) begin
        a.status = ST_NOT_DUE;
      end else begin
        h = due_order[0];
        if (now >= deadline_tab[h]) begin
          unlink_slot(h);
          if (rearm_tab[h]) begin
            deadline_tab[h] = now + period_tab[h];
            link_slot(h);
          end
          a.fired      = 1'b1;
          a.fired_slot = h;
        end else begin
          a.status = ST_NOT_DUE;
        end
      end
    end else if (int'(s) >= NSLOT) begin
      a.status = ST_NOT_QUEUED;
    end else if (cmd == CMD_REGISTER) begin
      period_tab[s] = ivl;
      rearm_tab[s]  = per;
    end else if (cmd == CMD_START) begin
      if (armed_tab[s]) unlink_slot(s);
      deadline_tab[s] = now + dly + period_tab[s];
      link_slot(s);
    end else begin
      if (armed_tab[s]) begin
        unlink_slot(s);
      end else begin
        a.status = ST_NOT_QUEUED;
      end
    end
    return a;
  endfunction

  // Predict on every accepted command word, compare on every accepted result word
  always @(posedge clk) begin
    timer_answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        period_tab[i]   = '0;
        deadline_tab[i] = '0;
        rearm_tab[i]    = 1'b0;
        armed_tab[i]    = 1'b0;
      end
      due_order.delete();
      timer_answers.delete();
    end else begin
      if (in_valid && !in_stall) begin
        timer_answers.push_back(apply_timer_cmd(cmd_t'(in_command), in_slot, in_interval,
                                                in_periodic, in_delay, in_now));
      end
      if (out_valid && !out_stall) begin
        if (timer_answers.size() == 0) begin
          $display("%0t: result word with none expected: fired %0d slot %0d status %0d",
                   $time, out_fired, out_fired_slot, out_status);
          fail_count++;
        end else begin
          want = timer_answers.pop_front();
          if (out_fired !== want.fired) begin
            $display("%0t: fired mismatch: expected %0d, actual %0d",
                     $time, want.fired, out_fired);
            fail_count++;
          end
          if (out_fired_slot !== want.fired_slot) begin
            $display("%0t: fired_slot mismatch: expected %0d, actual %0d",
                     $time, want.fired_slot, out_fired_slot);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            fail_count++;
          end
        end
      end
    end
    outstanding = timer_answers.size();
  end

endmodule

// File: dv/deadline_ordered_timer_queue_test.sv
`timescale 1ns / 1ps
// Testbench top for the deadline ordered timer queue: clock, reset, command stimulus,
// result stall pattern and verdict. Depends on dotq_pkg, dotq_checker and the block.
module deadline_ordered_timer_queue_test;
  import dotq_pkg::*;

  localparam int TW = DEF_TIME_BITS;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = '0;
  logic [SLOT_IN_W-1:0] in_slot = '0;
  logic [TW-1:0]        in_interval = '0;
  logic                 in_periodic = 1'b0;
  logic [TW-1:0]        in_delay = '0;
  logic [TW-1:0]        in_now = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_fired;
  logic [SLOT_IN_W-1:0] out_fired_slot;
  logic [STATUS_W-1:0]  out_status;

  int mismatches;
  int awaiting;

  // Sender pacing and receiver stall pattern
  int          burst_left = 0;
  bit          calm = 1'b0;
  stall_mode_t stall_mode = STALL_OFF;
  int          stall_left = 0;
  logic [7:0]  stall_phase = '0;

  deadline_ordered_timer_queue uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_slot       (in_slot),
    .in_interval   (in_interval),
    .in_periodic   (in_periodic),
    .in_delay      (in_delay),
    .in_now        (in_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_fired     (out_fired),
    .out_fired_slot(out_fired_slot),
    .out_status    (out_status)
  );

  dotq_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_slot       (in_slot),
    .in_interval   (in_interval),
    .in_periodic   (in_periodic),
    .in_delay      (in_delay),
    .in_now        (in_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_fired     (out_fired),
    .out_fired_slot(out_fired_slot),
    .out_status    (out_status),
    .fail_count    (mismatches),
    .outstanding   (awaiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result channel: off, random, or long runs, switching mode at random intervals
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_RUNS:   out_stall <= (stall_phase[3:0] < 4'd11);
      default:      out_stall <= 1'b0;
    endcase
  end

  // Offer one command word, hold it until accepted, then maybe pause between bursts
  task automatic push_word(input cmd_t cmd, input logic [SLOT_IN_W-1:0] slot,
                           input logic [TW-1:0] ivl, input logic per,
                           input logic [TW-1:0] dly, input logic [TW-1:0] now);
    int gap;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_slot     <= slot;
    in_interval <= ivl;
    in_periodic <= per;
    in_delay    <= dly;
    in_now      <= now;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = calm ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly short spans, sometimes zero, all ones or fully random
  function automatic logic [TW-1:0] pick_span(input int top);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, top);
    endcase
  endfunction

  initial begin
    logic [TW-1:0]        tnow;
    logic [TW-1:0]        now_v;
    logic [SLOT_IN_W-1:0] slot;
    cmd_t                 cmd;
    int                   roll;
    tnow = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, unqueued delete, never-registered start, due boundary
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, 32'd0);
    push_word(CMD_DELETE,   4'd5,  '0, 1'b0, '0, 32'd0);
    push_word(CMD_START,    4'd3,  '1, 1'b1, '0, 32'd100);
    push_word(CMD_TICK,     4'd3,  '1, 1'b1, '1, 32'd99);
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, 32'd100);
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, 32'd200);
    // Extremes of interval and mode, wrapping deadlines, equal deadlines
    push_word(CMD_REGISTER, 4'd0,  '1, 1'b1, '0, '0);
    push_word(CMD_REGISTER, 4'd15, 32'd10, 1'b0, '1, '1);
    push_word(CMD_REGISTER, 4'd7,  32'd0, 1'b1, '0, '0);
    push_word(CMD_START,    4'd0,  '0, 1'b0, '0, 32'd5);
    push_word(CMD_START,    4'd15, '0, 1'b0, '1, 32'd0);
    push_word(CMD_START,    4'd7,  '0, 1'b0, '0, 32'd9);
    // Restart while queued, re-register while queued
    push_word(CMD_START,    4'd15, '0, 1'b0, 32'hFFFF_FFF0, 32'd0);
    push_word(CMD_REGISTER, 4'd7,  32'd3, 1'b1, '0, '0);
    // Periodic rearm that wraps back to the head, then its removal
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, 32'd4);
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, 32'd4);
    push_word(CMD_DELETE,   4'd0,  '0, 1'b0, '0, '0);
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, 32'd9);
    push_word(CMD_DELETE,   4'd7,  '0, 1'b0, '0, '0);
    push_word(CMD_DELETE,   4'd7,  '0, 1'b0, '0, '0);
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, '1);
    push_word(CMD_REGISTER, 4'd9,  32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    push_word(CMD_REGISTER, 4'd9,  32'hAAAA_AAAA, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    push_word(CMD_TICK,     4'd0,  '0, 1'b0, '0, '1);

    // Random: mostly moving time forward, occasional jumps and backward times
    for (int n = 0; n < 1150; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      slot = SLOT_IN_W'($urandom_range(0, 15));
      if (roll < 15) cmd = CMD_REGISTER;
      else if (roll < 45) cmd = CMD_START;
      else if (roll < 85) cmd = CMD_TICK;
      else cmd = CMD_DELETE;
      if (cmd == CMD_TICK || cmd == CMD_START) begin
        case ($urandom_range(0, 39))
          0:       tnow = $urandom;
          1:       tnow = tnow + $urandom;
          default: tnow = tnow + $urandom_range(0, 6);
        endcase
      end
      now_v = ($urandom_range(0, 19) == 0) ? TW'($urandom) : tnow;
      push_word(cmd, slot, pick_span(40), 1'($urandom_range(0, 1)), pick_span(20), now_v);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain, then let the block settle
    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
